// File: sv/md5he_pkg.sv
// Package: MD5 engine types, constants and round tables.
package md5he_pkg;

	typedef struct packed {
		logic       is_last;
		logic       has_data;
		logic [7:0] data_byte;
	} md5he_req_t;

	typedef struct packed {
		logic [63:0] digest_high;
		logic [63:0] digest_low;
	} md5he_rsp_t;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	function automatic logic [31:0] round_k(input logic [5:0] r);
		logic [31:0] k;
		case (r)
			6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
			6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
			6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
			6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] round_s(input logic [5:0] r);
		logic [4:0] s;
		case ({r[5:4], r[1:0]})
			4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
			4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
			4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

	function automatic logic [3:0] word_sel(input logic [5:0] r);
		logic [3:0] g;
		case (r[5:4])
			2'd0: g = r[3:0];
			2'd1: g = 4'(r[3:0] * 4'd5 + 4'd1);
			2'd2: g = 4'(r[3:0] * 4'd3 + 4'd5);
			default: g = 4'(r[3:0] * 4'd7);
		endcase
		return g;
	endfunction

endpackage

// File: sv/md5he_ram.sv
// Generic single-port-write, registered-read RAM.
module md5he_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: sv/md5_hash_engine_unit.sv
// MD5 streaming engine top level: byte gathering, padding and round sequencer.
// A byte that does not complete a block is just gathered; a block-completing byte
// adds a read-priming step, 64 rounds through one adder chain, and one chain add.
// A last item adds padding at one byte per cycle, one or two compressions, then
// the digest waits in an output register. No byte is taken in the meantime.
// Reset loads the MD5 initial chain, clears position and count; block RAM is not reset.
module md5_hash_engine_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  md5he_pkg::md5he_req_t  in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output md5he_pkg::md5he_rsp_t  out_data
);
	import md5he_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_PAD, ST_LEN, ST_RND, ST_ADD, ST_OUT
	} state_t;

	state_t      state_q;
	logic [5:0]  pos_q;
	logic [63:0] cnt_q;
	logic [31:0] ha_q, hb_q, hc_q, hd_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [5:0]  rnd_q;
	logic        prime_q;
	logic        closing_q;
	logic        second_q;

	logic        ram_we;
	logic [3:0]  ram_waddr;
	logic [31:0] ram_wdata;
	logic [3:0]  ram_raddr;
	logic [31:0] ram_rdata;
	logic [31:0] wbuf_q;

	// words assembled in wbuf_q before a 32-bit write
	logic [7:0]  wr_byte;
	logic        wr_en;
	logic [31:0] wmerge;

	always_comb begin
		wmerge = wbuf_q;
		case (pos_q[1:0])
			2'd0: wmerge[7:0] = wr_byte;
			2'd1: wmerge[15:8] = wr_byte;
			2'd2: wmerge[23:16] = wr_byte;
			default: wmerge[31:24] = wr_byte;
		endcase
	end

	assign ram_we    = wr_en && (pos_q[1:0] == 2'd3);
	assign ram_waddr = pos_q[5:2];
	assign ram_wdata = wmerge;

	logic [5:0] rnd_next;
	assign rnd_next  = rnd_q + 6'd1;
	assign ram_raddr = word_sel(prime_q ? rnd_q : rnd_next);

	md5he_ram #(.WIDTH(32), .DEPTH(16)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	logic [31:0] mix, sum, rot;
	logic [4:0]  sh;
	always_comb begin
		case (rnd_q[5:4])
			2'd0: mix = (b_q & c_q) | (~b_q & d_q);
			2'd1: mix = (d_q & b_q) | (~d_q & c_q);
			2'd2: mix = b_q ^ c_q ^ d_q;
			default: mix = c_q ^ (b_q | ~d_q);
		endcase
		sum = a_q + mix + round_k(rnd_q) + ram_rdata;
		sh  = round_s(rnd_q);
		rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
	end

	logic in_fire, out_fire;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = (state_q == ST_OUT);
	assign out_fire  = out_valid && out_ready;

	// byte written this cycle
	always_comb begin
		wr_en   = 1'b0;
		wr_byte = 8'h00;
		case (state_q)
			ST_IDLE: begin
				wr_en   = in_fire && in_data.has_data;
				wr_byte = in_data.data_byte;
			end
			ST_PAD: begin
				wr_en   = 1'b1;
				wr_byte = second_q ? 8'h00 : PAD_BYTE;
			end
			ST_LEN: begin
				wr_en   = 1'b1;
				wr_byte = cnt_q[8*pos_q[2:0] +: 8];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			cnt_q     <= '0;
			ha_q      <= INIT_A;
			hb_q      <= INIT_B;
			hc_q      <= INIT_C;
			hd_q      <= INIT_D;
			a_q       <= '0;
			b_q       <= '0;
			c_q       <= '0;
			d_q       <= '0;
			wbuf_q    <= '0;
			rnd_q     <= '0;
			prime_q   <= 1'b0;
			closing_q <= 1'b0;
			second_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				pos_q  <= pos_q + 6'd1;
				wbuf_q <= wmerge;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						closing_q <= in_data.is_last;
						second_q  <= 1'b0;
						if (in_data.has_data) begin
							cnt_q <= cnt_q + 64'd8;
						end
						if (in_data.has_data && pos_q == 6'd63) begin
							state_q <= ST_RND;
							prime_q <= 1'b1;
							rnd_q   <= '0;
						end else if (in_data.is_last) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					// first cycle writes 0x80, then zeros until length or block end
					second_q <= 1'b1;
					if (pos_q == 6'd55) begin
						state_q <= ST_LEN;
					end else if (pos_q == 6'd63) begin
						state_q <= ST_RND;
						prime_q <= 1'b1;
						rnd_q   <= '0;
					end
				end
				ST_LEN: begin
					if (pos_q == 6'd63) begin
						state_q   <= ST_RND;
						prime_q   <= 1'b1;
						rnd_q     <= '0;
						closing_q <= 1'b0;
					end
				end
				ST_RND: begin
					if (prime_q) begin
						prime_q <= 1'b0;
						a_q <= ha_q;
						b_q <= hb_q;
						c_q <= hc_q;
						d_q <= hd_q;
					end else begin
						a_q <= d_q;
						d_q <= c_q;
						c_q <= b_q;
						b_q <= b_q + rot;
						rnd_q <= rnd_next;
						if (rnd_q == 6'd63) begin
							state_q <= ST_ADD;
						end
					end
				end
				ST_ADD: begin
					ha_q <= ha_q + a_q;
					hb_q <= hb_q + b_q;
					hc_q <= hc_q + c_q;
					hd_q <= hd_q + d_q;
					if (closing_q) begin
						state_q <= ST_PAD;
					end else if (second_q) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_fire) begin
						state_q  <= ST_IDLE;
						second_q <= 1'b0;
						pos_q    <= '0;
						cnt_q    <= '0;
						ha_q     <= INIT_A;
						hb_q     <= INIT_B;
						hc_q     <= INIT_C;
						hd_q     <= INIT_D;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_data.digest_low  = {hb_q, ha_q};
	assign out_data.digest_high = {hd_q, hc_q};

`ifndef NO_ASSERTIONS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("ready while digest pending");
	a_out_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pos_q == 6'd0) else $error("digest with partial block");
	a_rnd_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD) |-> $past(rnd_q) == 6'd63) else $error("short compression");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("digest changed while stalled");
`endif
endmodule

// File: sim/md5_hash_engine_unit_test.sv
// Testbench for the MD5 streaming engine: byte stream stimulus against an in-bench model.
module md5_hash_engine_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import md5he_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 200;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	md5he_req_t in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	md5he_rsp_t out_data;

	md5_hash_engine_unit u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data)
	);

	always #4 clk = ~clk;

	// digest model state
	logic [31:0] chain_q [4];
	logic [7:0]  blk_q [64];
	logic [5:0]  pos_q;
	logic [63:0] nbits_q;
	md5he_rsp_t  digest_q [$];
	md5he_rsp_t  last_dig = '0;

	int mismatches = 0;
	int idle_cycles = 0;
	bit timed_out = 1'b0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	localparam logic [31:0] SINE_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};
	localparam int SHIFT_T [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

	function automatic logic [31:0] rotl(logic [31:0] v, int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	task automatic chain_restart();
		chain_q[0] = 32'h67452301;
		chain_q[1] = 32'hefcdab89;
		chain_q[2] = 32'h98badcfe;
		chain_q[3] = 32'h10325476;
		pos_q = '0;
		nbits_q = '0;
	endtask

	task automatic fold_block();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, f, t;
		int g;
		a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
		for (int i = 0; i < 16; i++)
			w[i] = {blk_q[4*i+3], blk_q[4*i+2], blk_q[4*i+1], blk_q[4*i]};
		for (int r = 0; r < 64; r++) begin
			case (r / 16)
				0: begin f = (b & c) | (~b & d); g = r; end
				1: begin f = (d & b) | (~d & c); g = (5*r + 1) % 16; end
				2: begin f = b ^ c ^ d; g = (3*r + 5) % 16; end
				default: begin f = c ^ (b | ~d); g = (7*r) % 16; end
			endcase
			t = d; d = c; c = b;
			b = b + rotl(a + f + SINE_K[r] + w[g], SHIFT_T[(r/16)*4 + r%4]);
			a = t;
		end
		chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d;
	endtask

	task automatic absorb_request(md5he_req_t rq);
		md5he_rsp_t dg;
		if (rq.has_data) begin
			blk_q[pos_q] = rq.data_byte;
			pos_q++;
			nbits_q += 64'd8;
			if (pos_q == 0) fold_block();
		end
		if (rq.is_last) begin
			blk_q[pos_q] = PAD_BYTE;
			for (int k = pos_q + 1; k < 64; k++) blk_q[k] = 8'h00;
			if (pos_q >= 56) begin
				fold_block();
				for (int k = 0; k < 56; k++) blk_q[k] = 8'h00;
			end
			for (int k = 0; k < 8; k++) blk_q[56+k] = nbits_q[8*k +: 8];
			fold_block();
			dg.digest_low  = {chain_q[1], chain_q[0]};
			dg.digest_high = {chain_q[3], chain_q[2]};
			digest_q.push_back(dg);
			chain_restart();
		end
	endtask

	// valid stays up between back-to-back requests; dropped for idle gaps and by stop_sending
	task automatic send_request(logic l, logic h, logic [7:0] b);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
			while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
				@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{is_last: l, has_data: h, data_byte: b};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic stop_sending();
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_message(int len);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(19) == 0) send_request(1'b0, 1'b0, 8'($urandom));
			send_request(1'b0, 1'b1, 8'($urandom));
		end
		if ($urandom_range(1)) send_request(1'b1, 1'b1, 8'($urandom));
		else send_request(1'b1, 1'b0, 8'($urandom));
	endtask

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) absorb_request(in_data);
		if (arst_n && out_valid && out_ready) begin
			last_dig = out_data;
			if (digest_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected digest %h", out_data);
			end else begin
				md5he_rsp_t e;
				e = digest_q.pop_front();
				if (out_data.digest_low !== e.digest_low ||
				    out_data.digest_high !== e.digest_high) begin
					mismatches++;
					if (mismatches <= 10)
						$display("digest mismatch: exp %h_%h got %h_%h",
							e.digest_high, e.digest_low,
							out_data.digest_high, out_data.digest_low);
				end
			end
		end
	end

	always @(negedge clk)
		out_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("TB_ERROR");
			$finish;
		end
	end

	// directed: {is_last, has_data, byte}; known digests checked where typed in
	typedef struct {
		logic l; logic h; logic [7:0] b;
		bit known; logic [127:0] dig;
	} row_t;
	row_t dir_rows [] = '{
		'{1'b1, 1'b0, 8'h00, 1'b1, {64'h7e42f8ec980980e9, 64'h04b2008fd98c1dd4}},
		'{1'b0, 1'b0, 8'hff, 1'b0, '0},
		'{1'b1, 1'b1, 8'h61, 1'b0, '0},
		'{1'b0, 1'b1, 8'h00, 1'b0, '0},
		'{1'b0, 1'b1, 8'hff, 1'b0, '0},
		'{1'b0, 1'b0, 8'h00, 1'b0, '0},
		'{1'b1, 1'b1, 8'h80, 1'b0, '0},
		'{1'b1, 1'b1, 8'h00, 1'b0, '0},
		'{1'b1, 1'b1, 8'hff, 1'b0, '0},
		'{1'b1, 1'b0, 8'hff, 1'b0, '0}
	};

	initial begin
		int lens [] = '{55, 56, 57, 63, 64, 65};
		chain_restart();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (dir_rows[i]) begin
			send_request(dir_rows[i].l, dir_rows[i].h, dir_rows[i].b);
			if (dir_rows[i].known) begin
				stop_sending();
				while (digest_q.size() != 0) @(negedge clk);
				if (last_dig !== dir_rows[i].dig) begin
					mismatches++;
					if (mismatches <= 10)
						$display("directed digest: exp %h got %h",
							dir_rows[i].dig, last_dig);
				end
			end
		end
		foreach (lens[i]) send_message(lens[i]);
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 61 : 0;
			recv_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 26 : 0;
			for (int m = 0; m < 10; m++)
				send_message(($urandom_range(7) == 0) ? $urandom_range(56, 72)
					: $urandom_range(0, 8));
			stop_sending();
			while (digest_q.size() != 0) @(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule
